>>> rtl/lmsd_pkg.sv
package lmsd_pkg;

  // Default panel limits
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 256;

  // Register reset values
  localparam int ROWS_RESET = 64;
  localparam int COLS_RESET = 256;

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int PROW_W     = 6;
  localparam int PCOL_W     = 8;
  localparam int ROWS_CFG_W = 7;
  localparam int COLS_CFG_W = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int LANES      = 4;
  localparam int ROWADDR_W  = 4;

  // Stored pixel: bit 0 red, bit 1 green
  localparam int PIX_W = 2;

  // Input function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_SLEEP = 2'd2,
    FUNC_WAKE  = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

endpackage

>>> rtl/lmsd_store.sv
module lmsd_store #(
  parameter int AW = 14
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [lmsd_pkg::PIX_W-1:0]    wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [lmsd_pkg::PIX_W-1:0]    rd_data
);

  logic [lmsd_pkg::PIX_W-1:0] mem [2**AW];
  logic [lmsd_pkg::PIX_W-1:0] rd_data_r;

  // Single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/led_matrix_scan_driver_top.sv
// Write and wake transactions leave the input ready for the next item.
// A scan tick makes four quarter reads from the single read port of the frame store, then
// loads the result register once the output is free; out_tvalid rises with that load.
// A result can wait at the output while later writes are taken.
// Reset (synchronous, rst_n low) fills all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) store
// addresses (16384 by default) with the test grid; sleep runs the same pass with zeros.
module led_matrix_scan_driver_top #(
  parameter int MAX_ROWS = lmsd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lmsd_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [lmsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lmsd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lmsd_pkg::IN_DATA_W-1:0]      in_tdata,  // pixel_row, pixel_col, red_on, green_on
  input  logic [lmsd_pkg::FUNC_W-1:0]         in_tuser,  // func
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lmsd_pkg::OUT_DATA_W-1:0]     out_tdata, // red_lanes, green_lanes, row_address
  output logic [0:0]                          out_tuser, // latch
  output logic                                out_tlast  // frame_last
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int AW  = RW + CW;
  localparam int QW  = $clog2(MAX_ROWS / 4 + 1);
  localparam int CEW = $clog2(MAX_COLS + 1);
  localparam int LANES_ACC_W = lmsd_pkg::LANES - 1;

  // Rows per quarter from a height value
  function automatic logic [QW-1:0] calc_q(input logic [lmsd_pkg::ROWS_CFG_W-1:0] v);
    int r;
    r = int'(v);
    if (r > MAX_ROWS) r = MAX_ROWS;
    if (r < 4) r = 4;
    return QW'(r / 4);
  endfunction

  // Effective width from a width value
  function automatic logic [CEW-1:0] calc_cols(input logic [lmsd_pkg::COLS_CFG_W-1:0] v);
    int c;
    c = int'(v);
    if (c > MAX_COLS) c = MAX_COLS;
    if (c < 1) c = 1;
    return CEW'(c);
  endfunction

  localparam logic [QW-1:0]  Q_RST    = calc_q(lmsd_pkg::ROWS_CFG_W'(lmsd_pkg::ROWS_RESET));
  localparam logic [CEW-1:0] COLS_RST = calc_cols(lmsd_pkg::COLS_CFG_W'(lmsd_pkg::COLS_RESET));

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_RD,
    S_FIN
  } state_t;

  // Configuration, kept in effective form
  logic [QW-1:0]  q_r;
  logic [CEW-1:0] cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r    <= Q_RST;
      cols_r <= COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmsd_pkg::REG_ROWS_IN_USE: q_r    <= calc_q(cfg_wdata[lmsd_pkg::ROWS_CFG_W-1:0]);
        lmsd_pkg::REG_COLS_IN_USE: cols_r <= calc_cols(cfg_wdata);
      endcase
    end
  end

  // Input unpacking
  lmsd_pkg::func_t               in_func;
  logic [lmsd_pkg::PROW_W-1:0]   in_prow;
  logic [lmsd_pkg::PCOL_W-1:0]   in_pcol;
  logic                          in_red;
  logic                          in_green;

  assign in_func  = lmsd_pkg::func_t'(in_tuser);
  assign in_prow  = in_tdata[5:0];
  assign in_pcol  = in_tdata[13:6];
  assign in_red   = in_tdata[14];
  assign in_green = in_tdata[15];

  // Control state
  state_t                     state_r;
  logic                       paused_r;
  logic                       fill_grid_r;
  logic [AW-1:0]              fill_addr_r;
  logic [RW-1:0]              scan_row_r;
  logic [CW-1:0]              scan_col_r;
  logic [RW-1:0]              cur_row_r;
  logic [CW-1:0]              cur_col_r;
  logic [RW-1:0]              rd_row_r;
  logic [1:0]                 k_r;
  logic [LANES_ACC_W-1:0]     red_acc_r;
  logic [LANES_ACC_W-1:0]     green_acc_r;
  logic                       out_tvalid_r;
  logic [lmsd_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic                       out_latch_r;
  logic                       out_tlast_r;

  // Memory port signals
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [lmsd_pkg::PIX_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [lmsd_pkg::PIX_W-1:0] mem_rdata;

  logic in_acc;
  logic wr_hit;
  logic out_free;
  logic [RW-1:0] tick_row;
  logic [CW-1:0] tick_col;
  logic          fin_latch;
  logic          grid_bit;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // Pixel write qualifies when running and inside the panel
  assign wr_hit = in_acc && (in_func == lmsd_pkg::FUNC_WRITE) && !paused_r &&
                  (32'(in_prow) < 32'({q_r, 2'b00})) && (32'(in_pcol) < 32'(cols_r));

  // Test grid: lit where row or column is a multiple of four
  assign grid_bit = (fill_addr_r[CW+1:CW] == 2'b00) || (fill_addr_r[1:0] == 2'b00);

  always_comb begin
    if (state_r == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = fill_addr_r;
      mem_wdata = (fill_grid_r && grid_bit) ? 2'b11 : 2'b00;
    end else begin
      mem_we    = wr_hit;
      mem_waddr = {RW'(in_prow), CW'(in_pcol)};
      mem_wdata = {in_green, in_red};
    end
  end

  assign mem_re    = (state_r == S_RD);
  assign mem_raddr = {rd_row_r, cur_col_r};

  // Scan position brought back inside the panel for a tick
  always_comb begin
    tick_row = scan_row_r;
    tick_col = scan_col_r;
    if (32'(scan_row_r) >= 32'(q_r)) begin
      tick_row = RW'(q_r - QW'(1));
      tick_col = '0;
    end
    if (32'(tick_col) >= 32'(cols_r)) begin
      tick_col = '0;
    end
  end

  assign fin_latch = (32'(cur_col_r) == 32'(cols_r) - 32'd1);

  lmsd_store #(
    .AW(AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Sequencer: fill pass, item decode, quarter reads, result load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      paused_r     <= 1'b0;
      fill_grid_r  <= 1'b1;
      fill_addr_r  <= '0;
      scan_row_r   <= RW'(Q_RST - QW'(1));
      scan_col_r   <= '0;
      k_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // result taken; a load in S_FIN below sets it again
      if (out_tvalid_r && out_tready && state_r != S_FIN) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_FILL: begin
          fill_addr_r <= fill_addr_r + AW'(1);
          if (fill_addr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_func)
              lmsd_pkg::FUNC_WRITE: ;
              lmsd_pkg::FUNC_TICK: begin
                if (!paused_r) begin
                  scan_row_r <= tick_row;
                  scan_col_r <= tick_col;
                  cur_row_r  <= tick_row;
                  cur_col_r  <= tick_col;
                  rd_row_r   <= tick_row;
                  k_r        <= '0;
                  state_r    <= S_RD;
                end
              end
              lmsd_pkg::FUNC_SLEEP: begin
                paused_r    <= 1'b1;
                fill_grid_r <= 1'b0;
                fill_addr_r <= '0;
                state_r     <= S_FILL;
              end
              lmsd_pkg::FUNC_WAKE: begin
                paused_r <= 1'b0;
              end
            endcase
          end
        end
        S_RD: begin
          rd_row_r <= rd_row_r + RW'(q_r);
          k_r      <= k_r + 2'd1;
          if (k_r != 2'd0) begin
            red_acc_r[2'(k_r - 2'd1)]   <= mem_rdata[0];
            green_acc_r[2'(k_r - 2'd1)] <= mem_rdata[1];
          end
          if (k_r == 2'd3) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {4'b0000, (lmsd_pkg::ROWADDR_W)'(32'(cur_row_r)),
                             mem_rdata[1], green_acc_r, mem_rdata[0], red_acc_r};
            out_latch_r  <= fin_latch;
            out_tlast_r  <= fin_latch && (cur_row_r == '0);
            if (fin_latch) begin
              scan_col_r <= '0;
              scan_row_r <= (cur_row_r == '0) ? RW'(q_r - QW'(1)) : cur_row_r - RW'(1);
            end else begin
              scan_col_r <= cur_col_r + CW'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_latch_r;
  assign out_tlast    = out_tlast_r;

  // A tick while paused must not start a scan
  a_paused_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_func == lmsd_pkg::FUNC_TICK && paused_r) |=> (state_r == S_IDLE))
    else $error("scan started while paused");

  // Pixel writes only land while running
  a_write_running: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != S_FILL) |-> !paused_r)
    else $error("pixel write while paused");

  // Frame end is only marked on a row latch
  a_frame_on_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[0])
    else $error("frame_last without latch");

  // A latched row restarts at column zero
  a_latch_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free && fin_latch) |=> (scan_col_r == '0))
    else $error("column not rewound after latch");

  // Reads never overlap the fill pass
  a_no_read_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> !mem_re)
    else $error("store read during fill pass");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int FILL_CYCLES =
    1 << ($clog2(lmsd_pkg::MAX_ROWS_DEF) + $clog2(lmsd_pkg::MAX_COLS_DEF));
  localparam int WATCHDOG_CYCLES = 3 * FILL_CYCLES;
  localparam int LONG_HOLD = 300;
  localparam int N_PHASES = 10;
  localparam int PHASE_ITEMS = 77;
  localparam int PHASE_ROWS [N_PHASES] = '{4, 8, 16, 127, 64, 0, 20, 63, 12, 44};
  localparam int PHASE_COLS [N_PHASES] = '{1, 3, 5, 7, 256, 0, 16, 2, 511, 10};

  // One scan column as it leaves the block
  typedef struct packed {
    logic [3:0] red_lanes;
    logic [3:0] green_lanes;
    logic [3:0] row_address;
    logic       latch;
    logic       frame_last;
  } scan_result_t;

  typedef struct packed {
    lmsd_pkg::func_t func;
    logic [5:0]      prow;
    logic [7:0]      pcol;
    logic            red;
    logic            green;
  } pixel_cmd_t;

  localparam int CMD_W = $bits(pixel_cmd_t);

  typedef enum logic [1:0] {STEP_ITEM, STEP_ROWS, STEP_COLS} step_kind_t;

  typedef struct packed {
    step_kind_t      kind;
    lmsd_pkg::func_t func;
    logic [5:0]      prow;
    logic [7:0]      pcol;
    logic            red;
    logic            green;
    logic [8:0]      reg_val;
    logic            typed;
    scan_result_t    typed_res;
  } dir_step_t;

  localparam scan_result_t NO_RES = '0;

  // Directed sequence; typed results only where obvious
  localparam int N_DIR = 29;
  localparam dir_step_t DIR_STEPS [N_DIR] = '{
    // reset grid, first column of top row address
    '{STEP_ITEM, lmsd_pkg::FUNC_TICK,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b1,
      '{4'hF, 4'hF, 4'd15, 1'b0, 1'b0}},
    '{STEP_ITEM, lmsd_pkg::FUNC_WRITE, 6'd63, 8'd255, 1'b1, 1'b0, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_WRITE, 6'd0,  8'd0,   1'b0, 1'b1, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_TICK,  6'd63, 8'd255, 1'b1, 1'b1, 9'd0,   1'b0, NO_RES},
    // smallest panel; scan row now beyond it
    '{STEP_ROWS, lmsd_pkg::FUNC_WRITE, 6'd0,  8'd0,   1'b0, 1'b0, 9'd4,   1'b0, NO_RES},
    '{STEP_COLS, lmsd_pkg::FUNC_WRITE, 6'd0,  8'd0,   1'b0, 1'b0, 9'd1,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_TICK,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b1,
      '{4'hE, 4'hF, 4'd0, 1'b1, 1'b1}},
    // writes outside height, then outside width
    '{STEP_ITEM, lmsd_pkg::FUNC_WRITE, 6'd4,  8'd0,   1'b1, 1'b1, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_WRITE, 6'd0,  8'd1,   1'b1, 1'b1, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_TICK,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    // zero settings clamp up
    '{STEP_ROWS, lmsd_pkg::FUNC_WRITE, 6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    '{STEP_COLS, lmsd_pkg::FUNC_WRITE, 6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_TICK,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    // oversize settings clamp down
    '{STEP_ROWS, lmsd_pkg::FUNC_WRITE, 6'd0,  8'd0,   1'b0, 1'b0, 9'd127, 1'b0, NO_RES},
    '{STEP_COLS, lmsd_pkg::FUNC_WRITE, 6'd0,  8'd0,   1'b0, 1'b0, 9'd511, 1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_TICK,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_TICK,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_TICK,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    // narrow the panel under the scan column
    '{STEP_COLS, lmsd_pkg::FUNC_WRITE, 6'd0,  8'd0,   1'b0, 1'b0, 9'd2,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_TICK,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_TICK,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    // sleep, paused tick and write, sleep again, double wake
    '{STEP_ITEM, lmsd_pkg::FUNC_SLEEP, 6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_TICK,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_WRITE, 6'd1,  8'd1,   1'b1, 1'b1, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_SLEEP, 6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_WAKE,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_WAKE,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_TICK,  6'd0,  8'd0,   1'b0, 1'b0, 9'd0,   1'b0, NO_RES},
    '{STEP_ITEM, lmsd_pkg::FUNC_WRITE, 6'd0,  8'd0,   1'b1, 1'b1, 9'd0,   1'b0, NO_RES}
  };

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [lmsd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lmsd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [lmsd_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [lmsd_pkg::FUNC_W-1:0]     in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lmsd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [0:0]                      out_tuser;
  logic                            out_tlast;

  // Predictor state
  logic [1:0] frame_store [lmsd_pkg::MAX_ROWS_DEF][lmsd_pkg::MAX_COLS_DEF];
  bit         paused_p;
  int         scan_row_p, scan_col_p;
  int         rows_cfg, cols_cfg;

  scan_result_t scan_expect_q [$];
  scan_result_t want;

  int  errors, n_items, n_counted, n_results, n_latch, n_frames, n_sleeps, n_settings;
  int  burst_left, idle_cycles, rx_cyc, rx_mode, hold_cnt;
  bit  sleep_since_idle, long_hold_req;

  led_matrix_scan_driver_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_height();
    int r = rows_cfg;
    if (r > lmsd_pkg::MAX_ROWS_DEF) r = lmsd_pkg::MAX_ROWS_DEF;
    r = r & ~3;
    if (r < 4) r = 4;
    return r;
  endfunction

  function automatic int eff_width();
    int c = cols_cfg;
    if (c > lmsd_pkg::MAX_COLS_DEF) c = lmsd_pkg::MAX_COLS_DEF;
    if (c < 1) c = 1;
    return c;
  endfunction

  // Advance the predictor by one command; returns 1 if it changed anything
  function automatic bit apply_cmd(input pixel_cmd_t cmd, output bit has_res,
                                   output scan_result_t res);
    int h, w, q;
    logic [1:0] px;
    bit effective;
    h = eff_height();
    w = eff_width();
    q = h / 4;
    has_res = 1'b0;
    res = '0;
    effective = 1'b0;
    case (cmd.func)
      lmsd_pkg::FUNC_WRITE: begin
        if (!paused_p && int'(cmd.prow) < h && int'(cmd.pcol) < w) begin
          frame_store[cmd.prow][cmd.pcol] = {cmd.green, cmd.red};
          effective = 1'b1;
        end
      end
      lmsd_pkg::FUNC_SLEEP: begin
        paused_p = 1'b1;
        foreach (frame_store[r, c]) frame_store[r][c] = 2'b00;
        effective = 1'b1;
      end
      lmsd_pkg::FUNC_WAKE: begin
        effective = paused_p;
        paused_p = 1'b0;
      end
      lmsd_pkg::FUNC_TICK: begin
        if (!paused_p) begin
          // restart if the panel shrank under the scan position
          if (scan_row_p >= q) begin
            scan_row_p = q - 1;
            scan_col_p = 0;
          end
          if (scan_col_p >= w) scan_col_p = 0;
          for (int k = 0; k < lmsd_pkg::LANES; k++) begin
            px = frame_store[scan_row_p + k * q][scan_col_p];
            res.red_lanes[k] = px[0];
            res.green_lanes[k] = px[1];
          end
          res.row_address = 4'(scan_row_p);
          res.latch = (scan_col_p == w - 1);
          res.frame_last = res.latch && (scan_row_p == 0);
          if (res.latch) begin
            scan_col_p = 0;
            scan_row_p = (scan_row_p == 0) ? q - 1 : scan_row_p - 1;
          end else begin
            scan_col_p++;
          end
          has_res = 1'b1;
          effective = 1'b1;
        end
      end
    endcase
    return effective;
  endfunction

  function automatic void check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  // Sender pacing: bursts with random gaps in between
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 10);
    end
  endtask

  task automatic send_cmd(input pixel_cmd_t cmd, input bit typed, input scan_result_t typed_res);
    bit has_res;
    scan_result_t res;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd.func;
    in_tdata  <= {cmd.green, cmd.red, cmd.pcol, cmd.prow};
    do @(posedge clk); while (!in_tready);
    if (apply_cmd(cmd, has_res, res)) n_counted++;
    if (has_res) scan_expect_q.push_back(typed ? typed_res : res);
    if (cmd.func == lmsd_pkg::FUNC_SLEEP) begin
      sleep_since_idle = 1'b1;
      n_sleeps++;
    end
    n_items++;
    pace();
  endtask

  // Stop offering, drain results, let any clearing pass finish
  task automatic wait_idle();
    if (in_tvalid) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (scan_expect_q.size() != 0) @(posedge clk);
    repeat (sleep_since_idle ? FILL_CYCLES + 16 : 16) @(posedge clk);
    sleep_since_idle = 1'b0;
  endtask

  task automatic write_reg(input logic [lmsd_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= lmsd_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lmsd_pkg::REG_ROWS_IN_USE) rows_cfg = val & 'h7F;
    else cols_cfg = val & 'h1FF;
    @(posedge clk);
  endtask

  // Receiver: stall pattern picked at random among four modes, plus one long hold
  always @(posedge clk) begin
    rx_cyc++;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cnt = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (rx_cyc % 4 != 0);
        default: out_tready <= (rx_cyc % 7 == 0);
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (scan_expect_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual data %h latch %b last %b",
                 $time, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        want = scan_expect_q.pop_front();
        check_field("red_lanes",   want.red_lanes,   out_tdata[3:0]);
        check_field("green_lanes", want.green_lanes, out_tdata[7:4]);
        check_field("row_address", want.row_address, out_tdata[11:8]);
        check_field("latch",       want.latch,       out_tuser[0]);
        check_field("frame_last",  want.frame_last,  out_tlast);
        n_results++;
        if (want.latch) n_latch++;
        if (want.frame_last) n_frames++;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, idle_cycles, scan_expect_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    pixel_cmd_t cmd;
    int pick, target;
    bit drained_once;

    // predictor after reset: test grid, full panel
    foreach (frame_store[r, c])
      frame_store[r][c] = (r % 4 == 0 || c % 4 == 0) ? 2'b11 : 2'b00;
    paused_p = 1'b0;
    rows_cfg = lmsd_pkg::ROWS_RESET;
    cols_cfg = lmsd_pkg::COLS_RESET;
    scan_row_p = eff_height() / 4 - 1;
    scan_col_p = 0;
    drained_once = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    for (int i = 0; i < N_DIR; i++) begin
      case (DIR_STEPS[i].kind)
        STEP_ROWS: begin
          wait_idle();
          write_reg(lmsd_pkg::REG_ROWS_IN_USE, DIR_STEPS[i].reg_val);
          n_settings++;
        end
        STEP_COLS: begin
          wait_idle();
          write_reg(lmsd_pkg::REG_COLS_IN_USE, DIR_STEPS[i].reg_val);
          n_settings++;
        end
        default: begin
          cmd.func  = DIR_STEPS[i].func;
          cmd.prow  = DIR_STEPS[i].prow;
          cmd.pcol  = DIR_STEPS[i].pcol;
          cmd.red   = DIR_STEPS[i].red;
          cmd.green = DIR_STEPS[i].green;
          send_cmd(cmd, DIR_STEPS[i].typed, DIR_STEPS[i].typed_res);
        end
      endcase
    end

    // random part, one panel setting per phase
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      write_reg(lmsd_pkg::REG_ROWS_IN_USE, PHASE_ROWS[ph]);
      write_reg(lmsd_pkg::REG_COLS_IN_USE, PHASE_COLS[ph]);
      n_settings++;
      if (ph == 2) long_hold_req = 1'b1;
      target = n_items + PHASE_ITEMS;
      while (n_items < target) begin
        if (ph == 5 && !drained_once && n_items >= target - PHASE_ITEMS / 2) begin
          wait_idle();
          drained_once = 1'b1;
        end
        cmd = pixel_cmd_t'(CMD_W'($urandom));
        pick = $urandom_range(0, 199);
        if (pick < 3) begin
          cmd.func = lmsd_pkg::FUNC_SLEEP;
        end else if (pick < 23) begin
          cmd.func = lmsd_pkg::FUNC_WAKE;
        end else if (pick < 100) begin
          cmd.func = lmsd_pkg::FUNC_WRITE;
          // mostly on the panel, some anywhere in the field range
          if ($urandom_range(0, 6) != 0) begin
            cmd.prow = 6'($urandom_range(0, eff_height() - 1));
            cmd.pcol = 8'($urandom_range(0, eff_width() - 1));
          end
        end else begin
          cmd.func = lmsd_pkg::FUNC_TICK;
        end
        send_cmd(cmd, 1'b0, NO_RES);
      end
    end

    wait_idle();
    repeat (32) @(posedge clk);
    if (scan_expect_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, scan_expect_q.size());
      errors++;
    end

    $display("Sent %0d input transactions (%0d took effect), checked %0d scan columns.",
             n_items, n_counted, n_results);
    $display("%0d latches, %0d frame ends, %0d sleep clears, %0d panel settings; %0d mismatches.",
             n_latch, n_frames, n_sleeps, n_settings, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lmsd_pkg.sv
rtl/lmsd_store.sv
rtl/led_matrix_scan_driver_top.sv
sim/tb.sv
